[src/ps2kc_pkg.sv]
// ----------------------------------------------------------------------------
// PS/2 keyboard controller package
// Shared constants for the PS/2 keyboard and mouse controller: request
// codes, controller commands, status bits and queue sizes.
// ----------------------------------------------------------------------------
package ps2kc_pkg;

    // Queue depths and the widths that follow from them.
    localparam int RESP_DEPTH = 4;
    localparam int KBD_DEPTH  = 16;
    localparam int AUX_DEPTH  = 16;

    localparam int RESP_AW = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
    localparam int KBD_AW  = $clog2(KBD_DEPTH);
    localparam int AUX_AW  = $clog2(AUX_DEPTH);
    localparam int RESP_CW = $clog2(RESP_DEPTH + 1);
    localparam int KBD_CW  = $clog2(KBD_DEPTH + 1);
    localparam int AUX_CW  = $clog2(AUX_DEPTH + 1);

    typedef logic [2:0] cmd_t;
    typedef logic [7:0] byte_t;
    typedef logic [1:0] target_t;
    typedef logic [1:0] err_t;
    typedef logic [1:0] prefix_t;

    // Request codes.
    localparam cmd_t CMD_READ_DATA   = 3'd0;
    localparam cmd_t CMD_READ_STATUS = 3'd1;
    localparam cmd_t CMD_WRITE_DATA  = 3'd2;
    localparam cmd_t CMD_WRITE_CMD   = 3'd3;
    localparam cmd_t CMD_KBD_BYTE    = 3'd4;
    localparam cmd_t CMD_AUX_BYTE    = 3'd5;

    // Controller commands.
    localparam byte_t CC_READ_MODE  = 8'h20;
    localparam byte_t CC_WRITE_MODE = 8'h60;
    localparam byte_t CC_SELF_TEST  = 8'hAA;
    localparam byte_t CC_KBD_TEST   = 8'hAB;
    localparam byte_t CC_WRITE_AUX  = 8'hD4;

    localparam byte_t RESP_SELF_TEST_OK = 8'h55;
    localparam byte_t RESP_KBD_TEST_OK  = 8'h00;

    // Status and mode bits.
    localparam byte_t STAT_OUT_FULL = 8'h01;
    localparam byte_t STAT_AUX_DATA = 8'h20;
    localparam int    MODE_KBD_IRQ  = 0;
    localparam int    MODE_AUX_IRQ  = 1;

    localparam prefix_t PFX_NONE = 2'd0;
    localparam prefix_t PFX_MODE = 2'd1;
    localparam prefix_t PFX_AUX  = 2'd2;

    localparam target_t TGT_NONE = 2'd0;
    localparam target_t TGT_KBD  = 2'd1;
    localparam target_t TGT_AUX  = 2'd2;

    localparam err_t ERR_OK      = 2'd0;
    localparam err_t ERR_UNKNOWN = 2'd1;
    localparam err_t ERR_FULL    = 2'd2;

endpackage

[src/ps2_keyboard_controller_unit.sv]
// ----------------------------------------------------------------------------
// PS/2 keyboard controller unit
// Host data/status port handling, controller command decode, response queue,
// keyboard and mouse byte FIFOs and the single output latch.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                       | Direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, command, data_byte        | request in
//  out     | out_valid, out_stall, read_value, kbd_irq,    | result out
//          | aux_irq, device_write_target,                 |
//          | device_write_byte, error_code                 |
//
// Every request is decoded and all state is updated at the edge that accepts it,
// and its result lands in the output register.
// A new request is accepted every cycle while the output register is empty
// or being drained; in_stall rises only when a result waits under out_stall.
// Reset clears the mode byte, prefix, latch and all queue counts.
// ----------------------------------------------------------------------------
module ps2_keyboard_controller_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ps2kc_pkg::cmd_t    command,
    input  ps2kc_pkg::byte_t   data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output ps2kc_pkg::byte_t   read_value,
    output logic               kbd_irq,
    output logic               aux_irq,
    output ps2kc_pkg::target_t device_write_target,
    output ps2kc_pkg::byte_t   device_write_byte,
    output ps2kc_pkg::err_t    error_code
);
    import ps2kc_pkg::*;

    logic in_accept;

    // Controller state.
    byte_t   mode_reg, mode_next;
    prefix_t prefix_reg, prefix_next;
    byte_t   latch_byte_reg, latch_byte_next;
    logic    latch_full_reg, latch_full_next;
    logic    latch_aux_reg, latch_aux_next;

    // Queues.
    byte_t              resp_mem_reg [RESP_DEPTH];
    logic [RESP_AW-1:0] resp_head_reg, resp_head_next;
    logic [RESP_AW-1:0] resp_tail_reg, resp_tail_next;
    logic [RESP_CW-1:0] resp_count_reg, resp_count_next;
    byte_t              kbd_mem_reg [KBD_DEPTH];
    logic [KBD_AW-1:0]  kbd_head_reg, kbd_head_next;
    logic [KBD_AW-1:0]  kbd_tail_reg, kbd_tail_next;
    logic [KBD_CW-1:0]  kbd_count_reg, kbd_count_next;
    byte_t              aux_mem_reg [AUX_DEPTH];
    logic [AUX_AW-1:0]  aux_head_reg, aux_head_next;
    logic [AUX_AW-1:0]  aux_tail_reg, aux_tail_next;
    logic [AUX_CW-1:0]  aux_count_reg, aux_count_next;

    // Output register.
    logic    out_valid_reg, out_valid_next;
    byte_t   rd_reg, rd_next;
    logic    kirq_reg, kirq_next;
    logic    airq_reg, airq_next;
    target_t tgt_reg, tgt_next;
    byte_t   wb_reg, wb_next;
    err_t    err_reg, err_next;

    // Combinational decode.
    logic  do_load;
    logic  resp_req, kbd_req, aux_req;
    logic  resp_push, kbd_push, aux_push;
    logic  resp_pop, kbd_pop, aux_pop;
    byte_t resp_push_byte;
    byte_t resp_front, kbd_front, aux_front;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        mode_next       = mode_reg;
        prefix_next     = prefix_reg;
        latch_byte_next = latch_byte_reg;
        latch_full_next = latch_full_reg;
        latch_aux_next  = latch_aux_reg;
        rd_next         = '0;
        tgt_next        = TGT_NONE;
        wb_next         = '0;
        err_next        = ERR_OK;
        kirq_next       = 1'b0;
        airq_next       = 1'b0;
        do_load         = 1'b1;
        resp_req        = 1'b0;
        kbd_req         = 1'b0;
        aux_req         = 1'b0;
        resp_push_byte  = RESP_KBD_TEST_OK;
        resp_pop        = 1'b0;
        kbd_pop         = 1'b0;
        aux_pop         = 1'b0;

        case (command)
            CMD_READ_DATA:
            begin
                rd_next         = latch_full_reg ? latch_byte_reg : '0;
                latch_full_next = 1'b0;
            end
            CMD_READ_STATUS:
            begin
                if (latch_full_reg)
                begin
                    rd_next = latch_aux_reg ? (STAT_OUT_FULL | STAT_AUX_DATA)
                                            : STAT_OUT_FULL;
                end
                do_load = 1'b0;
            end
            CMD_WRITE_DATA:
            begin
                if (prefix_reg == PFX_MODE)
                begin
                    mode_next   = data_byte;
                    prefix_next = PFX_NONE;
                end
                else if (prefix_reg == PFX_AUX)
                begin
                    tgt_next    = TGT_AUX;
                    wb_next     = data_byte;
                    prefix_next = PFX_NONE;
                end
                else
                begin
                    tgt_next = TGT_KBD;
                    wb_next  = data_byte;
                end
            end
            CMD_WRITE_CMD:
            begin
                case (data_byte)
                    CC_READ_MODE:
                    begin
                        resp_req       = 1'b1;
                        resp_push_byte = mode_reg;
                    end
                    CC_WRITE_MODE: prefix_next = PFX_MODE;
                    CC_SELF_TEST:
                    begin
                        resp_req       = 1'b1;
                        resp_push_byte = RESP_SELF_TEST_OK;
                    end
                    CC_KBD_TEST:
                    begin
                        resp_req       = 1'b1;
                        resp_push_byte = RESP_KBD_TEST_OK;
                    end
                    CC_WRITE_AUX:  prefix_next = PFX_AUX;
                    default:       err_next = ERR_UNKNOWN;
                endcase
            end
            CMD_KBD_BYTE: kbd_req = 1'b1;
            CMD_AUX_BYTE: aux_req = 1'b1;
            default:      do_load = 1'b0;
        endcase

        resp_push = resp_req && (resp_count_reg != RESP_CW'(RESP_DEPTH));
        kbd_push  = kbd_req && (kbd_count_reg != KBD_CW'(KBD_DEPTH));
        aux_push  = aux_req && (aux_count_reg != AUX_CW'(AUX_DEPTH));
        if ((resp_req && !resp_push) || (kbd_req && !kbd_push) || (aux_req && !aux_push))
        begin
            err_next = ERR_FULL;
        end

        // A byte pushed into an empty queue can be popped at once.
        resp_front = (resp_count_reg != '0) ? resp_mem_reg[resp_head_reg] : resp_push_byte;
        kbd_front  = (kbd_count_reg != '0) ? kbd_mem_reg[kbd_head_reg] : data_byte;
        aux_front  = (aux_count_reg != '0) ? aux_mem_reg[aux_head_reg] : data_byte;

        if (do_load && !latch_full_next)
        begin
            if (resp_count_reg != '0 || resp_push)
            begin
                resp_pop        = 1'b1;
                latch_byte_next = resp_front;
                latch_full_next = 1'b1;
                latch_aux_next  = 1'b0;
                kirq_next       = mode_next[MODE_KBD_IRQ];
            end
            else if (kbd_count_reg != '0 || kbd_push)
            begin
                kbd_pop         = 1'b1;
                latch_byte_next = kbd_front;
                latch_full_next = 1'b1;
                latch_aux_next  = 1'b0;
                kirq_next       = mode_next[MODE_KBD_IRQ];
            end
            else if (aux_count_reg != '0 || aux_push)
            begin
                aux_pop         = 1'b1;
                latch_byte_next = aux_front;
                latch_full_next = 1'b1;
                latch_aux_next  = 1'b1;
                airq_next       = mode_next[MODE_AUX_IRQ];
            end
        end

        resp_count_next = resp_count_reg + RESP_CW'(resp_push) - RESP_CW'(resp_pop);
        kbd_count_next  = kbd_count_reg + KBD_CW'(kbd_push) - KBD_CW'(kbd_pop);
        aux_count_next  = aux_count_reg + AUX_CW'(aux_push) - AUX_CW'(aux_pop);

        resp_head_next = resp_head_reg;
        resp_tail_next = resp_tail_reg;
        kbd_head_next  = kbd_head_reg;
        kbd_tail_next  = kbd_tail_reg;
        aux_head_next  = aux_head_reg;
        aux_tail_next  = aux_tail_reg;
        if (resp_pop)
        begin
            resp_head_next = (resp_head_reg == RESP_AW'(RESP_DEPTH - 1)) ? '0
                                                                     : resp_head_reg + 1'b1;
        end
        if (resp_push)
        begin
            resp_tail_next = (resp_tail_reg == RESP_AW'(RESP_DEPTH - 1)) ? '0
                                                                     : resp_tail_reg + 1'b1;
        end
        if (kbd_pop)
        begin
            kbd_head_next = (kbd_head_reg == KBD_AW'(KBD_DEPTH - 1)) ? '0 : kbd_head_reg + 1'b1;
        end
        if (kbd_push)
        begin
            kbd_tail_next = (kbd_tail_reg == KBD_AW'(KBD_DEPTH - 1)) ? '0 : kbd_tail_reg + 1'b1;
        end
        if (aux_pop)
        begin
            aux_head_next = (aux_head_reg == AUX_AW'(AUX_DEPTH - 1)) ? '0 : aux_head_reg + 1'b1;
        end
        if (aux_push)
        begin
            aux_tail_next = (aux_tail_reg == AUX_AW'(AUX_DEPTH - 1)) ? '0 : aux_tail_reg + 1'b1;
        end

        out_valid_next = in_accept ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            prefix_reg     <= PFX_NONE;
            latch_full_reg <= 1'b0;
            latch_aux_reg  <= 1'b0;
            latch_byte_reg <= '0;
            resp_head_reg  <= '0;
            resp_tail_reg  <= '0;
            resp_count_reg <= '0;
            kbd_head_reg   <= '0;
            kbd_tail_reg   <= '0;
            kbd_count_reg  <= '0;
            aux_head_reg   <= '0;
            aux_tail_reg   <= '0;
            aux_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                mode_reg       <= mode_next;
                prefix_reg     <= prefix_next;
                latch_full_reg <= latch_full_next;
                latch_aux_reg  <= latch_aux_next;
                latch_byte_reg <= latch_byte_next;
                resp_head_reg  <= resp_head_next;
                resp_tail_reg  <= resp_tail_next;
                resp_count_reg <= resp_count_next;
                kbd_head_reg   <= kbd_head_next;
                kbd_tail_reg   <= kbd_tail_next;
                kbd_count_reg  <= kbd_count_next;
                aux_head_reg   <= aux_head_next;
                aux_tail_reg   <= aux_tail_next;
                aux_count_reg  <= aux_count_next;
            end
        end
    end

    // Queue storage and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (resp_push)
            begin
                resp_mem_reg[resp_tail_reg] <= resp_push_byte;
            end
            if (kbd_push)
            begin
                kbd_mem_reg[kbd_tail_reg] <= data_byte;
            end
            if (aux_push)
            begin
                aux_mem_reg[aux_tail_reg] <= data_byte;
            end
            rd_reg   <= rd_next;
            kirq_reg <= kirq_next;
            airq_reg <= airq_next;
            tgt_reg  <= tgt_next;
            wb_reg   <= wb_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign read_value          = rd_reg;
    assign kbd_irq             = kirq_reg;
    assign aux_irq             = airq_reg;
    assign device_write_target = tgt_reg;
    assign device_write_byte   = wb_reg;
    assign error_code          = err_reg;

    // Queue counts never pass their depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (resp_count_reg <= RESP_CW'(RESP_DEPTH)) && (kbd_count_reg <= KBD_CW'(KBD_DEPTH))
        && (aux_count_reg <= AUX_CW'(AUX_DEPTH)))
    else $error("queue count beyond depth");

    // After any request that loads the latch, an empty latch means every queue is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == CMD_READ_DATA || command == CMD_WRITE_DATA
            || command == CMD_WRITE_CMD || command == CMD_KBD_BYTE
            || command == CMD_AUX_BYTE))
        |=> (latch_full_reg || (resp_count_reg == '0 && kbd_count_reg == '0
            && aux_count_reg == '0)))
    else $error("latch left empty while a queue holds data");

    // Only one interrupt can be raised per request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(kirq_reg && airq_reg))
    else $error("both interrupts raised by one request");

    // A mouse interrupt always comes with a latch byte marked as from the mouse.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && airq_next |=> latch_full_reg && latch_aux_reg)
    else $error("mouse interrupt without mouse byte in latch");

    // A device write never goes out alongside an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (tgt_reg != TGT_NONE) |-> (err_reg == ERR_OK))
    else $error("device write reported with an error");

endmodule

[dv/ps2_keyboard_controller_unit_tb.sv]
// ----------------------------------------------------------------------------
// PS/2 keyboard controller unit testbench
// Drives host accesses and device bytes through the request channel and
// checks every result against a cycle-free predictor of the controller:
// mode byte, command prefix, output latch, response queue and device FIFOs.
// Covers directed corner cases, then random well-formed command sequences,
// FIFO floods and noise under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ps2_keyboard_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2kc_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int RANDOM_PHASES   = 4;
    localparam int HOLD_CYCLES     = 150;
    localparam int SETTLE_CYCLES   = 10;
    localparam int CYCLE_LIMIT     = 400000;

    // Request codes that the block treats as no operation.
    localparam cmd_t CMD_NOP_6 = 3'd6;
    localparam cmd_t CMD_NOP_7 = 3'd7;

    typedef struct packed {
        cmd_t  cmd;
        byte_t data;
    } host_req_t;

    typedef struct packed {
        byte_t   rd;
        logic    kirq;
        logic    airq;
        target_t tgt;
        byte_t   wb;
        err_t    err;
    } host_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    cmd_t    command   = CMD_READ_DATA;
    byte_t   data_byte = 8'h00;
    logic    out_valid;
    logic    out_stall = 1'b0;
    byte_t   read_value;
    logic    kbd_irq;
    logic    aux_irq;
    target_t device_write_target;
    byte_t   device_write_byte;
    err_t    error_code;

    ps2_keyboard_controller_unit dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .command             (command),
        .data_byte           (data_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .read_value          (read_value),
        .kbd_irq             (kbd_irq),
        .aux_irq             (aux_irq),
        .device_write_target (device_write_target),
        .device_write_byte   (device_write_byte),
        .error_code          (error_code)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller predictor
    // ------------------------------------------------------------------
    byte_t   mode_reg      = 8'h00;
    prefix_t prefix_reg    = PFX_NONE;
    byte_t   latch_byte    = 8'h00;
    logic    latch_full    = 1'b0;
    logic    latch_aux     = 1'b0;
    byte_t   response_fifo[$];
    byte_t   kbd_fifo[$];
    byte_t   aux_fifo[$];

    host_req_t    pending_requests[$];
    host_result_t expected_results[$];

    int failures          = 0;
    int accepted_requests = 0;
    int results_seen      = 0;
    int planned_requests  = 0;
    int device_writes     = 0;
    int irq_pulses        = 0;
    int dropped_bytes     = 0;
    int unknown_commands  = 0;
    int hold_requests     = 0;
    bit steady_sender     = 1'b0;

    function automatic err_t queue_response(byte_t b);
        if (response_fifo.size() < RESP_DEPTH)
        begin
            response_fifo.insert(response_fifo.size(), b);
            return ERR_OK;
        end
        return ERR_FULL;
    endfunction

    function automatic host_result_t predict_access(cmd_t cmd, byte_t v);
        host_result_t r;
        logic         load;
        r    = '0;
        load = 1'b1;
        case (cmd)
            CMD_READ_DATA:
            begin
                r.rd       = latch_full ? latch_byte : 8'h00;
                latch_full = 1'b0;
            end
            CMD_READ_STATUS:
            begin
                if (latch_full)
                    r.rd = STAT_OUT_FULL | (latch_aux ? STAT_AUX_DATA : 8'h00);
                load = 1'b0;
            end
            CMD_WRITE_DATA:
            begin
                if (prefix_reg == PFX_MODE)
                begin
                    mode_reg   = v;
                    prefix_reg = PFX_NONE;
                end
                else if (prefix_reg == PFX_AUX)
                begin
                    r.tgt      = TGT_AUX;
                    r.wb       = v;
                    prefix_reg = PFX_NONE;
                end
                else
                begin
                    r.tgt = TGT_KBD;
                    r.wb  = v;
                end
            end
            CMD_WRITE_CMD:
            begin
                case (v)
                    CC_READ_MODE:  r.err = queue_response(mode_reg);
                    CC_WRITE_MODE: prefix_reg = PFX_MODE;
                    CC_SELF_TEST:  r.err = queue_response(RESP_SELF_TEST_OK);
                    CC_KBD_TEST:   r.err = queue_response(RESP_KBD_TEST_OK);
                    CC_WRITE_AUX:  prefix_reg = PFX_AUX;
                    default:       r.err = ERR_UNKNOWN;
                endcase
            end
            CMD_KBD_BYTE:
            begin
                if (kbd_fifo.size() < KBD_DEPTH)
                    kbd_fifo.insert(kbd_fifo.size(), v);
                else
                    r.err = ERR_FULL;
            end
            CMD_AUX_BYTE:
            begin
                if (aux_fifo.size() < AUX_DEPTH)
                    aux_fifo.insert(aux_fifo.size(), v);
                else
                    r.err = ERR_FULL;
            end
            default:
                load = 1'b0;
        endcase

        // An empty latch refills with responses first, then keyboard, then mouse.
        if (load && !latch_full)
        begin
            if (response_fifo.size() != 0)
            begin
                latch_byte = response_fifo[0];
                response_fifo.delete(0);
                latch_full = 1'b1;
                latch_aux  = 1'b0;
                r.kirq     = mode_reg[MODE_KBD_IRQ];
            end
            else if (kbd_fifo.size() != 0)
            begin
                latch_byte = kbd_fifo[0];
                kbd_fifo.delete(0);
                latch_full = 1'b1;
                latch_aux  = 1'b0;
                r.kirq     = mode_reg[MODE_KBD_IRQ];
            end
            else if (aux_fifo.size() != 0)
            begin
                latch_byte = aux_fifo[0];
                aux_fifo.delete(0);
                latch_full = 1'b1;
                latch_aux  = 1'b1;
                r.airq     = mode_reg[MODE_AUX_IRQ];
            end
        end

        if (r.tgt != TGT_NONE)
            device_writes++;
        if (r.kirq || r.airq)
            irq_pulses++;
        if (r.err == ERR_FULL)
            dropped_bytes++;
        if (r.err == ERR_UNKNOWN)
            unknown_commands++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    int        burst_left = 0;
    int        gap_left   = 0;
    host_req_t next_req;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.insert(expected_results.size(),
                                        predict_access(command, data_byte));
                accepted_requests++;
            end
            // A stalled request keeps its payload until it is taken.
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req  = pending_requests[0];
                    pending_requests.delete(0);
                    in_valid  <= 1'b1;
                    command   <= next_req.cmd;
                    data_byte <= next_req.data;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        if (steady_sender || $urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    stall_style_t stall_style = STALL_NONE;
    int           style_left  = 0;
    int           hold_left   = 0;
    int           hold_served = 0;
    host_result_t exp_r;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: read_value %0h", read_value);
                    failures++;
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    results_seen++;
                    if (read_value !== exp_r.rd)
                    begin
                        $error("read_value: expected %0h, got %0h", exp_r.rd, read_value);
                        failures++;
                    end
                    if (kbd_irq !== exp_r.kirq)
                    begin
                        $error("kbd_irq: expected %0b, got %0b", exp_r.kirq, kbd_irq);
                        failures++;
                    end
                    if (aux_irq !== exp_r.airq)
                    begin
                        $error("aux_irq: expected %0b, got %0b", exp_r.airq, aux_irq);
                        failures++;
                    end
                    if (device_write_target !== exp_r.tgt)
                    begin
                        $error("device_write_target: expected %0d, got %0d",
                               exp_r.tgt, device_write_target);
                        failures++;
                    end
                    if (device_write_byte !== exp_r.wb)
                    begin
                        $error("device_write_byte: expected %0h, got %0h",
                               exp_r.wb, device_write_byte);
                        failures++;
                    end
                    if (error_code !== exp_r.err)
                    begin
                        $error("error_code: expected %0d, got %0d", exp_r.err, error_code);
                        failures++;
                    end
                end
            end

            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(20, 80);
            end
            else
                style_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_style)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL ps2_keyboard_controller_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic byte_t random_byte();
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic byte_t random_query();
        case ($urandom_range(0, 2))
            0:       return CC_READ_MODE;
            1:       return CC_SELF_TEST;
            default: return CC_KBD_TEST;
        endcase
    endfunction

    task automatic queue_request(cmd_t c, byte_t d);
        pending_requests.insert(pending_requests.size(), host_req_t'{cmd: c, data: d});
        if (c <= CMD_AUX_BYTE)
            planned_requests++;
    endtask

    // Host polling: sometimes a status read before each data read.
    task automatic queue_reads(int n);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                queue_request(CMD_READ_STATUS, random_byte());
            queue_request(CMD_READ_DATA, random_byte());
        end
    endtask

    task automatic queue_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        if (kind <= 2)
        begin
            queue_request(CMD_WRITE_CMD, CC_WRITE_MODE);
            if ($urandom_range(0, 1))
                queue_request(CMD_WRITE_DATA, random_byte());
            else
                queue_request(CMD_WRITE_DATA, byte_t'($urandom_range(0, 3)));
        end
        else if (kind <= 4)
        begin
            queue_request(CMD_WRITE_CMD, CC_WRITE_AUX);
            queue_request(CMD_WRITE_DATA, random_byte());
        end
        else if (kind <= 7)
        begin
            queue_request(CMD_WRITE_CMD, random_query());
            queue_reads($urandom_range(1, 3));
        end
        else if (kind <= 10)
        begin
            n = $urandom_range(1, 6);
            repeat (n) queue_request(CMD_KBD_BYTE, random_byte());
            queue_reads(n);
        end
        else if (kind <= 12)
        begin
            n = $urandom_range(1, 5);
            repeat (n) queue_request(CMD_AUX_BYTE, random_byte());
            queue_reads(n);
        end
        else if (kind == 13)
        begin
            // Overrun one of the queues, then drain it.
            case ($urandom_range(0, 2))
                0:
                begin
                    n = KBD_DEPTH + $urandom_range(2, 4);
                    repeat (n) queue_request(CMD_KBD_BYTE, random_byte());
                end
                1:
                begin
                    n = AUX_DEPTH + $urandom_range(2, 4);
                    repeat (n) queue_request(CMD_AUX_BYTE, random_byte());
                end
                default:
                begin
                    n = RESP_DEPTH + $urandom_range(2, 4);
                    repeat (n) queue_request(CMD_WRITE_CMD, random_query());
                end
            endcase
            queue_reads(n);
        end
        else if (kind == 14)
        begin
            repeat ($urandom_range(1, 3)) queue_request(CMD_WRITE_DATA, random_byte());
        end
        else if (kind == 15)
        begin
            // A prefix interrupted by another controller command.
            queue_request(CMD_WRITE_CMD, $urandom_range(0, 1) ? CC_WRITE_MODE : CC_WRITE_AUX);
            if ($urandom_range(0, 1))
                queue_request(CMD_WRITE_CMD, $urandom_range(0, 1) ? CC_WRITE_MODE : CC_WRITE_AUX);
            else
                queue_request(CMD_WRITE_CMD, random_byte());
            queue_request(CMD_WRITE_DATA, random_byte());
        end
        else if (kind == 16)
        begin
            queue_request(CMD_WRITE_CMD, random_byte());
        end
        else if (kind <= 18)
        begin
            repeat ($urandom_range(1, 4))
                queue_request(cmd_t'($urandom_range(0, 7)), random_byte());
        end
        else
        begin
            queue_reads($urandom_range(1, 4));
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_request(CMD_READ_DATA, 8'h00);
        queue_request(CMD_READ_STATUS, 8'hFF);
        queue_request(CMD_NOP_6, 8'hFF);
        queue_request(CMD_NOP_7, 8'h00);
        queue_request(CMD_WRITE_CMD, CC_WRITE_MODE);
        queue_request(CMD_WRITE_DATA, 8'h03);
        queue_request(CMD_WRITE_CMD, CC_SELF_TEST);
        queue_request(CMD_READ_STATUS, 8'h00);
        queue_request(CMD_READ_DATA, 8'h00);
        queue_request(CMD_WRITE_CMD, CC_KBD_TEST);
        queue_request(CMD_WRITE_CMD, CC_READ_MODE);
        queue_request(CMD_READ_DATA, 8'h00);
        queue_request(CMD_READ_DATA, 8'h00);
        queue_request(CMD_WRITE_DATA, 8'h00);
        queue_request(CMD_WRITE_DATA, 8'hFF);
        queue_request(CMD_WRITE_CMD, CC_WRITE_AUX);
        queue_request(CMD_WRITE_DATA, 8'hA5);
        queue_request(CMD_WRITE_CMD, 8'hFF);
        // The mouse prefix replaces the pending mode write.
        queue_request(CMD_WRITE_CMD, CC_WRITE_MODE);
        queue_request(CMD_WRITE_CMD, CC_WRITE_AUX);
        queue_request(CMD_WRITE_DATA, 8'h5A);
        queue_request(CMD_AUX_BYTE, 8'hFA);
        queue_request(CMD_READ_STATUS, 8'h00);
        queue_request(CMD_READ_DATA, 8'h00);
        queue_request(CMD_KBD_BYTE, 8'h80);
        wait_until_quiet();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady_sender = (phase == 1);
            while (planned_requests < 25 + RANDOM_REQUESTS * (phase + 1) / RANDOM_PHASES)
                queue_random_sequence();
            // Long receiver hold-off while a full phase of requests is on offer.
            if (phase == 2)
                hold_requests++;
            wait_until_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d requests and %0d checked results in %0d cycles.",
                 accepted_requests, results_seen, cycle_count);
        $display("Device writes %0d, interrupt pulses %0d, dropped bytes %0d, unknown cmds %0d.",
                 device_writes, irq_pulses, dropped_bytes, unknown_commands);
        if (failures == 0)
            $display("PASS ps2_keyboard_controller_unit");
        else
            $display("FAIL ps2_keyboard_controller_unit");
        $finish;
    end

endmodule
